@@ rtl/tga_true_colour_stream_parser_assert.svh @@
// Assertion helpers for the TGA stream parser.
// Both macros expect signals named clk and rst in the module that uses them.
`ifndef TGA_TRUE_COLOUR_STREAM_PARSER_ASSERT_SVH
`define TGA_TRUE_COLOUR_STREAM_PARSER_ASSERT_SVH

// Same-cycle implication.
`define TGAP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tgap assertion failed");

// Next-cycle implication.
`define TGAP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tgap assertion failed");

`endif

@@ rtl/tgap_pkg.sv @@
// ----------------------------------------------------------------------------
// tgap_pkg
// Types and codes shared by the TGA true-colour stream parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tgap_pkg;

  // parse phases
  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_HEADER = 3'd1;
  localparam logic [2:0] PH_SKIP   = 3'd2;
  localparam logic [2:0] PH_PIXELS = 3'd3;
  localparam logic [2:0] PH_DONE   = 3'd4;

  // header byte positions
  localparam logic [4:0] HDR_ID_LEN     = 5'd0;
  localparam logic [4:0] HDR_MAP_TYPE   = 5'd1;
  localparam logic [4:0] HDR_IMAGE_TYPE = 5'd2;
  localparam logic [4:0] HDR_WIDTH_LO   = 5'd12;
  localparam logic [4:0] HDR_WIDTH_HI   = 5'd13;
  localparam logic [4:0] HDR_HEIGHT_LO  = 5'd14;
  localparam logic [4:0] HDR_HEIGHT_HI  = 5'd15;
  localparam logic [4:0] HDR_DEPTH      = 5'd16;
  localparam logic [4:0] HDR_LAST       = 5'd17;

  // byte slots within a pixel
  localparam logic [1:0] BYTE_BLUE  = 2'd0;
  localparam logic [1:0] BYTE_GREEN = 2'd1;
  localparam logic [1:0] BYTE_RED   = 2'd2;
  localparam logic [1:0] BYTE_ALPHA = 2'd3;

  localparam logic [7:0] TYPE_TRUE_COLOUR = 8'd2;
  localparam logic [7:0] DEPTH_24         = 8'd24;
  localparam logic [7:0] DEPTH_32         = 8'd32;
  localparam logic [7:0] ALPHA_OPAQUE     = 8'hFF;

  // result kinds
  localparam logic [1:0] KIND_PIXEL  = 2'd0;
  localparam logic [1:0] KIND_ACCEPT = 2'd1;
  localparam logic [1:0] KIND_REJECT = 2'd2;

  // error codes
  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_TYPE  = 2'd1;
  localparam logic [1:0] ERR_DEPTH = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [15:0] width;
    logic [15:0] height;
    logic [1:0]  err;
    logic        last;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/tgap_result_reg.sv @@
// ----------------------------------------------------------------------------
// tgap_result_reg
// Output register with valid/ready; takes a new result whenever the held one
// leaves in the same cycle or the register is empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tgap_result_reg (
  input  wire               clk,
  input  wire               rst,
  input  wire               load,
  input  tgap_pkg::result_t load_data,
  output logic              space,
  output logic              out_valid,
  input  wire               out_ready,
  output tgap_pkg::result_t out_data
);

  assign space = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (space) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (space && load) begin
      out_data <= load_data;
    end
  end

endmodule

`default_nettype wire

@@ rtl/tga_true_colour_stream_parser.sv @@
// ----------------------------------------------------------------------------
// tga_true_colour_stream_parser
// Results: built from the accepted byte that completes them, then registered.
// Throughput: one byte per cycle, limited only by the single output register.
// Reset: synchronous rst clears the parser to idle and empties the output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "tga_true_colour_stream_parser_assert.svh"

module tga_true_colour_stream_parser (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [7:0]  data_byte,
  input  wire         file_start,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [1:0]  result_kind,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue,
  output logic [7:0]  alpha,
  output logic [15:0] image_width,
  output logic [15:0] image_height,
  output logic [1:0]  error_code,
  output logic        last_pixel
);

  logic [2:0]  phase,         phase_next;
  logic [4:0]  header_pos,    header_pos_next;
  logic [7:0]  id_length,     id_length_next;
  logic        bad_map_type,  bad_map_type_next;
  logic [7:0]  image_type,    image_type_next;
  logic [15:0] width_value,   width_value_next;
  logic [15:0] height_value,  height_value_next;
  logic [7:0]  depth_value,   depth_value_next;
  logic [7:0]  skip_count,    skip_count_next;
  logic [1:0]  byte_in_pixel, byte_in_pixel_next;
  logic [7:0]  held_blue,     held_blue_next;
  logic [7:0]  held_green,    held_green_next;
  logic [7:0]  held_red,      held_red_next;
  logic [15:0] column_count,  column_count_next;
  logic [15:0] row_count,     row_count_next;

  logic              accept;
  logic [2:0]        cur_phase;
  logic              res_load;
  tgap_pkg::result_t res;
  tgap_pkg::result_t out_data;
  logic              space;
  logic              emit;
  logic [7:0]        emit_alpha;
  logic              last_col;
  logic              last_row;

  assign accept   = in_valid && in_ready;
  assign in_ready = space;

  always_comb begin
    phase_next         = phase;
    header_pos_next    = header_pos;
    id_length_next     = id_length;
    bad_map_type_next  = bad_map_type;
    image_type_next    = image_type;
    width_value_next   = width_value;
    height_value_next  = height_value;
    depth_value_next   = depth_value;
    skip_count_next    = skip_count;
    byte_in_pixel_next = byte_in_pixel;
    held_blue_next     = held_blue;
    held_green_next    = held_green;
    held_red_next      = held_red;
    column_count_next  = column_count;
    row_count_next     = row_count;
    res_load           = 1'b0;
    res                = '0;
    emit               = 1'b0;
    emit_alpha         = tgap_pkg::ALPHA_OPAQUE;
    last_col           = (column_count == width_value - 16'd1);
    last_row           = (row_count == height_value - 16'd1);
    cur_phase          = file_start ? tgap_pkg::PH_HEADER : phase;

    if (accept) begin
      if (file_start) begin
        header_pos_next    = '0;
        id_length_next     = '0;
        bad_map_type_next  = 1'b0;
        image_type_next    = '0;
        width_value_next   = '0;
        height_value_next  = '0;
        depth_value_next   = '0;
        skip_count_next    = '0;
        byte_in_pixel_next = '0;
        held_blue_next     = '0;
        held_green_next    = '0;
        held_red_next      = '0;
        column_count_next  = '0;
        row_count_next     = '0;
        phase_next         = tgap_pkg::PH_HEADER;
      end

      case (cur_phase)
        tgap_pkg::PH_HEADER: begin
          case (header_pos_next)
            tgap_pkg::HDR_ID_LEN:     id_length_next           = data_byte;
            tgap_pkg::HDR_MAP_TYPE:   bad_map_type_next        = (data_byte != 8'd0);
            tgap_pkg::HDR_IMAGE_TYPE: image_type_next          = data_byte;
            tgap_pkg::HDR_WIDTH_LO:   width_value_next[7:0]    = data_byte;
            tgap_pkg::HDR_WIDTH_HI:   width_value_next[15:8]   = data_byte;
            tgap_pkg::HDR_HEIGHT_LO:  height_value_next[7:0]   = data_byte;
            tgap_pkg::HDR_HEIGHT_HI:  height_value_next[15:8]  = data_byte;
            tgap_pkg::HDR_DEPTH:      depth_value_next         = data_byte;
            default: ;
          endcase
          if (header_pos_next == tgap_pkg::HDR_LAST) begin
            res_load   = 1'b1;
            res.width  = width_value_next;
            res.height = height_value_next;
            if (image_type_next != tgap_pkg::TYPE_TRUE_COLOUR || bad_map_type_next) begin
              res.err = tgap_pkg::ERR_TYPE;
            end else if (depth_value_next != tgap_pkg::DEPTH_24 &&
                         depth_value_next != tgap_pkg::DEPTH_32) begin
              res.err = tgap_pkg::ERR_DEPTH;
            end
            if (res.err != tgap_pkg::ERR_NONE) begin
              res.kind   = tgap_pkg::KIND_REJECT;
              phase_next = tgap_pkg::PH_DONE;
            end else begin
              res.kind = tgap_pkg::KIND_ACCEPT;
              if (width_value_next == 16'd0 || height_value_next == 16'd0) begin
                res.last   = 1'b1;
                phase_next = tgap_pkg::PH_DONE;
              end else if (id_length_next != 8'd0) begin
                skip_count_next = id_length_next;
                phase_next      = tgap_pkg::PH_SKIP;
              end else begin
                byte_in_pixel_next = tgap_pkg::BYTE_BLUE;
                column_count_next  = '0;
                row_count_next     = '0;
                phase_next         = tgap_pkg::PH_PIXELS;
              end
            end
          end else begin
            header_pos_next = header_pos_next + 5'd1;
          end
        end

        tgap_pkg::PH_SKIP: begin
          skip_count_next = skip_count - 8'd1;
          if (skip_count_next == 8'd0) begin
            byte_in_pixel_next = tgap_pkg::BYTE_BLUE;
            column_count_next  = '0;
            row_count_next     = '0;
            phase_next         = tgap_pkg::PH_PIXELS;
          end
        end

        tgap_pkg::PH_PIXELS: begin
          case (byte_in_pixel)
            tgap_pkg::BYTE_BLUE: begin
              held_blue_next     = data_byte;
              byte_in_pixel_next = tgap_pkg::BYTE_GREEN;
            end
            tgap_pkg::BYTE_GREEN: begin
              held_green_next    = data_byte;
              byte_in_pixel_next = tgap_pkg::BYTE_RED;
            end
            tgap_pkg::BYTE_RED: begin
              held_red_next = data_byte;
              if (depth_value == tgap_pkg::DEPTH_32) begin
                byte_in_pixel_next = tgap_pkg::BYTE_ALPHA;
              end else begin
                emit = 1'b1;
              end
            end
            default: begin
              emit       = 1'b1;
              emit_alpha = data_byte;
            end
          endcase
          if (emit) begin
            res_load           = 1'b1;
            res.kind           = tgap_pkg::KIND_PIXEL;
            res.red            = held_red_next;
            res.green          = held_green;
            res.blue           = held_blue;
            res.alpha          = emit_alpha;
            byte_in_pixel_next = tgap_pkg::BYTE_BLUE;
            if (last_col && last_row) begin
              res.last   = 1'b1;
              phase_next = tgap_pkg::PH_DONE;
            end else if (last_col) begin
              column_count_next = '0;
              row_count_next    = row_count + 16'd1;
            end else begin
              column_count_next = column_count + 16'd1;
            end
          end
        end

        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= tgap_pkg::PH_IDLE;
      header_pos    <= '0;
      id_length     <= '0;
      bad_map_type  <= 1'b0;
      image_type    <= '0;
      width_value   <= '0;
      height_value  <= '0;
      depth_value   <= '0;
      skip_count    <= '0;
      byte_in_pixel <= '0;
      column_count  <= '0;
      row_count     <= '0;
    end else begin
      phase         <= phase_next;
      header_pos    <= header_pos_next;
      id_length     <= id_length_next;
      bad_map_type  <= bad_map_type_next;
      image_type    <= image_type_next;
      width_value   <= width_value_next;
      height_value  <= height_value_next;
      depth_value   <= depth_value_next;
      skip_count    <= skip_count_next;
      byte_in_pixel <= byte_in_pixel_next;
      column_count  <= column_count_next;
      row_count     <= row_count_next;
    end
  end

  always_ff @(posedge clk) begin
    held_blue  <= held_blue_next;
    held_green <= held_green_next;
    held_red   <= held_red_next;
  end

  tgap_result_reg u_result_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (res_load),
    .load_data (res),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign result_kind  = out_data.kind;
  assign red          = out_data.red;
  assign green        = out_data.green;
  assign blue         = out_data.blue;
  assign alpha        = out_data.alpha;
  assign image_width  = out_data.width;
  assign image_height = out_data.height;
  assign error_code   = out_data.err;
  assign last_pixel   = out_data.last;

  `TGAP_ASSERT_NOW(a_pixel_dims, phase == tgap_pkg::PH_PIXELS,
    width_value != 16'd0 && height_value != 16'd0 && column_count < width_value)
  `TGAP_ASSERT_NOW(a_skip_nonzero, phase == tgap_pkg::PH_SKIP, skip_count != 8'd0)
  `TGAP_ASSERT_NOW(a_alpha_slot, byte_in_pixel == tgap_pkg::BYTE_ALPHA,
    depth_value == tgap_pkg::DEPTH_32)
  `TGAP_ASSERT_NOW(a_reject_not_last, out_valid && result_kind == tgap_pkg::KIND_REJECT,
    !last_pixel)
  `TGAP_ASSERT_NEXT(a_done_holds, accept && !file_start && phase == tgap_pkg::PH_DONE,
    phase == tgap_pkg::PH_DONE)

endmodule

`default_nettype wire
